### rtl/lpfr_pkg.sv
// ============================================================================
// lpfr_pkg: shared types and constants for the length-prefixed frame receiver
// This package holds the status and operation codes, the result record and
// the default buffer size.
// ============================================================================
`default_nettype none

package lpfr_pkg;

  // Default receive buffer capacity in bytes
  localparam int unsigned BufferBytesDef = 512;

  // Width of the reported frame length
  localparam int unsigned FrameLenW = 10;

  // Number of header bytes kept per frame
  localparam int unsigned HdrBytes = 5;

  // Input operation codes
  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_ABORT = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CARD_ERR = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_e;

  // Card error reply signature: "erro"
  localparam logic [7:0] ErrChar0 = 8'h65;
  localparam logic [7:0] ErrChar1 = 8'h72;
  localparam logic [7:0] ErrChar2 = 8'h72;
  localparam logic [7:0] ErrChar3 = 8'h6f;

  // One result record
  typedef struct packed {
    status_e                status;
    logic [7:0]             error_code;
    logic [FrameLenW-1:0]   frame_length;
  } result_t;

endpackage : lpfr_pkg

`default_nettype wire

### rtl/lpfr_in_if.sv
// ============================================================================
// lpfr_in_if: input byte channel
// Valid/ready channel carrying one operation and one received byte.
// ============================================================================
`default_nettype none

interface lpfr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface : lpfr_in_if

`default_nettype wire

### rtl/lpfr_out_if.sv
// ============================================================================
// lpfr_out_if: frame report channel
// Valid/ready channel carrying one frame report.
// ============================================================================
`default_nettype none

interface lpfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] error_code;
  logic [9:0] frame_length;

  modport source (output valid, output status, output error_code, output frame_length,
                  input ready);
  modport sink   (input valid, input status, input error_code, input frame_length,
                  output ready);
endinterface : lpfr_out_if

`default_nettype wire

### rtl/lpfr_core.sv
// ============================================================================
// lpfr_core: frame state and per-byte decision
// Keeps the byte count, running sum and header bytes, and decides on each
// accepted transaction whether a frame report is produced.
// ============================================================================
`default_nettype none

module lpfr_core #(
  parameter int unsigned BufferBytes = lpfr_pkg::BufferBytesDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic             op_i,
  input  wire logic [7:0]       rx_byte_i,
  output logic                  res_valid_o,
  output lpfr_pkg::result_t     res_o
);

  localparam int unsigned CntW  = $clog2(BufferBytes + 1);
  localparam int unsigned WideW = (CntW > 16) ? CntW : 16;
  localparam int unsigned NHdr  = lpfr_pkg::HdrBytes;

  logic [CntW-1:0]  count_q, count_d, count_inc;
  logic [7:0]       sum_q, sum_d, sum_inc;
  logic [7:0]       hdr_q [NHdr];
  logic [7:0]       hdr_d [NHdr];
  logic [7:0]       hdr_n [NHdr];
  logic [WideW-1:0] count_wide;
  logic [WideW-1:0] len_wide;
  logic             card_err, complete, overflow;

  // Merge the incoming byte into the header view
  always_comb begin
    for (int i = 0; i < NHdr; i++) begin
      hdr_n[i] = (count_q == CntW'(i)) ? rx_byte_i : hdr_q[i];
    end
  end

  assign count_inc  = count_q + CntW'(1);
  assign sum_inc    = sum_q + rx_byte_i;
  assign count_wide = WideW'(count_inc);
  assign len_wide   = WideW'({hdr_n[1], hdr_n[0]});

  // Detect card error reply, completion and overflow
  assign card_err = (count_inc == CntW'(4))
                    && (hdr_n[0] == lpfr_pkg::ErrChar0)
                    && (hdr_n[1] == lpfr_pkg::ErrChar1)
                    && (hdr_n[2] == lpfr_pkg::ErrChar2)
                    && (hdr_n[3] == lpfr_pkg::ErrChar3);
  assign complete = (count_inc >= CntW'(2)) && (count_wide == len_wide);
  assign overflow = (count_inc >= CntW'(BufferBytes));

  // Next state and report
  always_comb begin
    count_d                = count_q;
    sum_d                  = sum_q;
    hdr_d                  = hdr_q;
    res_valid_o            = 1'b0;
    res_o.status           = lpfr_pkg::ST_OK;
    res_o.error_code       = '0;
    res_o.frame_length     = count_wide[lpfr_pkg::FrameLenW-1:0];
    if (accept_i) begin
      if (op_i == lpfr_pkg::OP_ABORT) begin
        count_d = '0;
        sum_d   = '0;
        for (int i = 0; i < NHdr; i++) hdr_d[i] = '0;
      end else begin
        count_d = count_inc;
        sum_d   = sum_inc;
        hdr_d   = hdr_n;
        priority if (card_err) begin
          res_valid_o  = 1'b1;
          res_o.status = lpfr_pkg::ST_CARD_ERR;
        end else if (complete) begin
          res_valid_o = 1'b1;
          if (sum_inc != 8'd0) begin
            res_o.status = lpfr_pkg::ST_CHECKSUM;
          end else begin
            res_o.status     = lpfr_pkg::ST_OK;
            res_o.error_code = hdr_n[4];
          end
        end else if (overflow) begin
          res_valid_o  = 1'b1;
          res_o.status = lpfr_pkg::ST_OVERFLOW;
        end else begin
          res_valid_o = 1'b0;
        end
        // Clear the frame after any report
        if (res_valid_o) begin
          count_d = '0;
          sum_d   = '0;
          for (int i = 0; i < NHdr; i++) hdr_d[i] = '0;
        end
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      for (int i = 0; i < NHdr; i++) hdr_q[i] <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      hdr_q   <= hdr_d;
    end
  end

endmodule : lpfr_core

`default_nettype wire

### rtl/lpfr_out_buf.sv
// ============================================================================
// lpfr_out_buf: result register with skid stage
// Holds frame reports for the output channel; a second entry lets the core
// keep taking bytes while a report waits.
// ============================================================================
`default_nettype none

module lpfr_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire lpfr_pkg::result_t data_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output lpfr_pkg::result_t      data_o,
  input  wire logic              pop_ready_i
);

  logic              main_valid_q, main_valid_d;
  logic              skid_valid_q, skid_valid_d;
  lpfr_pkg::result_t main_q, main_d;
  lpfr_pkg::result_t skid_q, skid_d;
  logic              pop;

  assign pop     = main_valid_q && pop_ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  // Advance, fill or spill into the skid entry
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        main_d       = data_i;
      end
    end else if (push_i) begin
      if (!main_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = data_i;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule : lpfr_out_buf

`default_nettype wire

### rtl/length_prefixed_frame_receiver.sv
// ============================================================================
// length_prefixed_frame_receiver: reply frame receiver with additive checksum
// Top level joining the frame state logic and the report output stage.
// ============================================================================
// Takes one reply byte (or an abort) per transaction and accepts a new one
// every cycle. Bytes 0 and 1 give the frame length, low byte first; when that
// many bytes have arrived one report is issued: ok with byte 4 as error code,
// or checksum mismatch when the mod-256 sum of all bytes is nonzero. A reply
// starting with "erro" is reported as a card error on its fourth byte, and a
// frame reaching BufferBytes without completing is reported as overflow.
// Any report or abort clears the frame. A report is registered in the output
// stage before it appears on the output; a two-entry output stage keeps input
// flowing while one report waits, and input stalls only when both are full.
// ============================================================================
`default_nettype none

module length_prefixed_frame_receiver #(
  parameter int unsigned BufferBytes = lpfr_pkg::BufferBytesDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lpfr_in_if.sink     in_i,
  lpfr_out_if.source  out_o
);

  logic              accept;
  logic              buf_ready;
  logic              res_valid;
  lpfr_pkg::result_t res;
  lpfr_pkg::result_t out_data;

  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;

  // Frame state and decision
  lpfr_core #(
    .BufferBytes (BufferBytes)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (in_i.op),
    .rx_byte_i   (in_i.rx_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Report output stage
  lpfr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .ready_o     (buf_ready),
    .valid_o     (out_o.valid),
    .data_o      (out_data),
    .pop_ready_i (out_o.ready)
  );

  assign out_o.status       = out_data.status;
  assign out_o.error_code   = out_data.error_code;
  assign out_o.frame_length = out_data.frame_length;

endmodule : length_prefixed_frame_receiver

`default_nettype wire
